[hdl/grid_bfs_path_search_defines.svh]
// ----------------------------------------------------------------------------
// Grid BFS path search assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_BFS_PATH_SEARCH_DEFINES_SVH
`define GRID_BFS_PATH_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/gbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid BFS path search package
// Codes, defaults and shared types of the grid path search block.
// ----------------------------------------------------------------------------
package gbps_pkg;

   // Default grid store size.
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   // Width used for coordinate and dimension compares.
   localparam int CMP_W = 10;

   // Request operations.
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // Response status codes.
   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_FOUND  = 2'd1;
   localparam logic [1:0] STATUS_NOPATH = 2'd2;
   localparam logic [1:0] STATUS_RANGE  = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_GRID_ROWS = 3'd0;
   localparam logic [2:0] REG_GRID_COLS = 3'd1;
   localparam logic [2:0] REG_START_ROW = 3'd2;
   localparam logic [2:0] REG_START_COL = 3'd3;
   localparam logic [2:0] REG_GOAL_ROW  = 3'd4;
   localparam logic [2:0] REG_GOAL_COL  = 3'd5;

   // Register reset values.
   localparam logic [6:0] GRID_ROWS_RST = 7'd64;
   localparam logic [6:0] GRID_COLS_RST = 7'd64;
   localparam logic [5:0] START_ROW_RST = 6'd2;
   localparam logic [5:0] START_COL_RST = 6'd2;
   localparam logic [5:0] GOAL_ROW_RST  = 6'd7;
   localparam logic [5:0] GOAL_COL_RST  = 6'd2;

   // Neighbor expansion order.
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LEFT  = 2'd3;

   // Neighbor classification from the neighbor unit.
   typedef struct packed {
      logic in_grid;
      logic is_goal;
   } nbr_flags_type;

endpackage

[hdl/gbps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module gbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[hdl/gbps_nbr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid BFS neighbor unit
// Steps one cell in a direction, checks the grid bounds and the goal, and
// forms the cell store index of the neighbor.
// ----------------------------------------------------------------------------
module gbps_nbr #(
   parameter int RW       = 6,
   parameter int CW       = 6,
   parameter int IW       = 12,
   parameter int MAX_COLS = 64
) (
   input  logic [RW-1:0]               row,
   input  logic [CW-1:0]               col,
   input  logic [1:0]                  dir,
   input  logic [RW:0]                 rows,
   input  logic [CW:0]                 cols,
   input  logic [5:0]                  goal_row,
   input  logic [5:0]                  goal_col,
   output logic [RW-1:0]               nbr_row,
   output logic [CW-1:0]               nbr_col,
   output logic [IW-1:0]               nbr_idx,
   output gbps_pkg::nbr_flags_type     flags
);

   logic [RW:0] row_ext;
   logic [CW:0] col_ext;
   logic        step_ok;

   // Step and bounds check.
   always_comb begin
      row_ext = {1'b0, row};
      col_ext = {1'b0, col};
      step_ok = 1'b1;
      unique case (dir)
         gbps_pkg::DIR_UP: begin
            if (row == '0) step_ok = 1'b0;
            row_ext = row_ext - (RW+1)'(1);
         end
         gbps_pkg::DIR_DOWN: begin
            row_ext = row_ext + (RW+1)'(1);
         end
         gbps_pkg::DIR_RIGHT: begin
            col_ext = col_ext + (CW+1)'(1);
         end
         gbps_pkg::DIR_LEFT: begin
            if (col == '0) step_ok = 1'b0;
            col_ext = col_ext - (CW+1)'(1);
         end
         default: begin
            step_ok = 1'b0;
         end
      endcase
      flags.in_grid = step_ok && (row_ext < rows) && (col_ext < cols);
      flags.is_goal = (gbps_pkg::CMP_W'(row_ext) == gbps_pkg::CMP_W'(goal_row)) &&
                      (gbps_pkg::CMP_W'(col_ext) == gbps_pkg::CMP_W'(goal_col));
   end

   assign nbr_row = row_ext[RW-1:0];
   assign nbr_col = col_ext[CW-1:0];

   // Row-major cell index.
   assign nbr_idx = IW'(nbr_row) * IW'(MAX_COLS) + IW'(nbr_col);

endmodule

[hdl/grid_bfs_path_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid BFS path search
// Occupancy grid store with a 4-neighbor breadth-first path search.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one word per operation: op 0 writes a cell
// as free or blocked, op 1 runs a search from the start cell to the goal cell,
// op 2 reads one path cell, index 0 next to the goal. Each request gives one
// rsp word with status, path length and, for op 2, the path cell.
// The csr channel writes grid size, start and goal; csr_ready is always high.
// The user must see that writes are made only while the block is idle; the block itself does not enforce it.
// Op 0, op 3 and an out-of-range op 2 answer in the next cycle; a valid op 2
// answers after a path store read, then a node store read.
// A search first clears the visited marks, one cell a cycle, then reads each
// dequeued node from the node store and classifies its neighbors in turn,
// reading the cell bits of each one inside the grid; the trace back then walks
// the parent links through the node store, writing one path cell at each step.
// The single node store read port and the shared neighbor unit keep these steps in sequence.
// One request is in work at a time; req_stall is high while it runs.
// After reset the cell store is cleared while req_stall is high; csr writes
// are taken meanwhile.
// A stalled rsp word holds; the next request is taken once the rsp register
// is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module grid_bfs_path_search #(
   parameter int MAX_ROWS = gbps_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = gbps_pkg::MAX_COLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_cell_row,
   input  logic [5:0]  req_cell_col,
   input  logic        req_occupied,
   input  logic [11:0] req_path_index,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_path_length,
   output logic [5:0]  rsp_path_row,
   output logic [5:0]  rsp_path_col,
   // Register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CW     = $clog2(MAX_COLS);
   localparam int NCELLS = MAX_ROWS * MAX_COLS;
   localparam int IW     = $clog2(NCELLS);
   localparam int LW     = IW + 1;
   localparam int NW     = RW + CW + IW;
   localparam int PW     = (LW > 12) ? LW : 12;
   localparam int DW     = gbps_pkg::CMP_W;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_START,
      S_POP,
      S_NODE,
      S_DIR,
      S_CHECK,
      S_TRACE,
      S_TRACE_RD,
      S_FINISH,
      S_RD_PATH,
      S_RD_NODE
   } state_type;

   // Registers.
   state_type     state_ff, state_in;
   logic [IW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic          sweep_occ_ff, sweep_occ_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] count_ff, count_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [1:0]    dir_ff, dir_in;
   logic [RW-1:0] nbr_row_ff, nbr_row_in;
   logic [CW-1:0] nbr_col_ff, nbr_col_in;
   logic [IW-1:0] nbr_idx_ff, nbr_idx_in;
   logic [IW-1:0] trace_k_ff, trace_k_in;
   logic [LW-1:0] found_len_ff, found_len_in;
   logic          found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [11:0]   rsp_len_ff, rsp_len_in;
   logic [5:0]    rsp_row_ff, rsp_row_in;
   logic [5:0]    rsp_col_ff, rsp_col_in;
   logic [6:0]    grid_rows_ff, grid_cols_ff;
   logic [5:0]    start_row_ff, start_col_ff, goal_row_ff, goal_col_ff;

   // Memory ports.
   logic          occ_we, occ_wdata, occ_re, occ_rdata;
   logic [IW-1:0] occ_waddr;
   logic          vis_we, vis_wdata, vis_re, vis_rdata;
   logic [IW-1:0] vis_waddr;
   logic          node_we, node_re;
   logic [IW-1:0] node_waddr, node_raddr;
   logic [NW-1:0] node_wdata, node_rdata;
   logic          path_we, path_re;
   logic [IW-1:0] path_waddr, path_raddr;
   logic [IW-1:0] path_rdata;

   // Neighbor unit.
   logic [RW-1:0]           nbr_row;
   logic [CW-1:0]           nbr_col;
   logic [IW-1:0]           nbr_idx;
   gbps_pkg::nbr_flags_type nbr_flags;

   logic [DW-1:0] rows_c, cols_c;
   logic          start_ok, goal_ok, start_is_goal;
   logic          out_free, accept;
   logic [IW-1:0] start_idx, cell_idx;

   // Effective grid size: zero counts as one, clipped to the store size.
   always_comb begin
      if (grid_rows_ff == '0) rows_c = DW'(1);
      else if (DW'(grid_rows_ff) > DW'(MAX_ROWS)) rows_c = DW'(MAX_ROWS);
      else rows_c = DW'(grid_rows_ff);
      if (grid_cols_ff == '0) cols_c = DW'(1);
      else if (DW'(grid_cols_ff) > DW'(MAX_COLS)) cols_c = DW'(MAX_COLS);
      else cols_c = DW'(grid_cols_ff);
   end

   assign start_ok      = (DW'(start_row_ff) < rows_c) && (DW'(start_col_ff) < cols_c);
   assign goal_ok       = (DW'(goal_row_ff) < rows_c) && (DW'(goal_col_ff) < cols_c);
   assign start_is_goal = (start_row_ff == goal_row_ff) && (start_col_ff == goal_col_ff);
   assign start_idx     = IW'(start_row_ff) * IW'(MAX_COLS) + IW'(start_col_ff);
   assign cell_idx      = IW'(req_cell_row) * IW'(MAX_COLS) + IW'(req_cell_col);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   gbps_nbr #(
      .RW       (RW),
      .CW       (CW),
      .IW       (IW),
      .MAX_COLS (MAX_COLS)
   ) u_nbr (
      .row      (cur_row_ff),
      .col      (cur_col_ff),
      .dir      (dir_ff),
      .rows     (rows_c[RW:0]),
      .cols     (cols_c[CW:0]),
      .goal_row (goal_row_ff),
      .goal_col (goal_col_ff),
      .nbr_row  (nbr_row),
      .nbr_col  (nbr_col),
      .nbr_idx  (nbr_idx),
      .flags    (nbr_flags)
   );

   // Occupancy bits, visited marks, node queue and path list.
   gbps_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_occ_ram (
      .clock (clock), .we (occ_we), .waddr (occ_waddr), .wdata (occ_wdata),
      .re (occ_re), .raddr (nbr_idx), .rdata (occ_rdata)
   );

   gbps_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_vis_ram (
      .clock (clock), .we (vis_we), .waddr (vis_waddr), .wdata (vis_wdata),
      .re (vis_re), .raddr (nbr_idx), .rdata (vis_rdata)
   );

   gbps_ram #(.WIDTH(NW), .DEPTH(NCELLS)) u_node_ram (
      .clock (clock), .we (node_we), .waddr (node_waddr), .wdata (node_wdata),
      .re (node_re), .raddr (node_raddr), .rdata (node_rdata)
   );

   gbps_ram #(.WIDTH(IW), .DEPTH(NCELLS)) u_path_ram (
      .clock (clock), .we (path_we), .waddr (path_waddr), .wdata (trace_k_ff),
      .re (path_re), .raddr (path_raddr), .rdata (path_rdata)
   );

   assign path_waddr = IW'(found_len_ff);
   assign path_raddr = IW'(req_path_index);

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_occ_in  = sweep_occ_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      dir_in        = dir_ff;
      nbr_row_in    = nbr_row_ff;
      nbr_col_in    = nbr_col_ff;
      nbr_idx_in    = nbr_idx_ff;
      trace_k_in    = trace_k_ff;
      found_len_in  = found_len_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      occ_we        = 1'b0;
      occ_waddr     = sweep_cnt_ff;
      occ_wdata     = 1'b0;
      occ_re        = 1'b0;
      vis_we        = 1'b0;
      vis_waddr     = sweep_cnt_ff;
      vis_wdata     = 1'b0;
      vis_re        = 1'b0;
      node_we       = 1'b0;
      node_waddr    = IW'(count_ff);
      node_wdata    = {nbr_row_ff, nbr_col_ff, IW'(head_ff)};
      node_re       = 1'b0;
      node_raddr    = IW'(head_ff);
      path_we       = 1'b0;
      path_re       = 1'b0;

      unique case (state_ff)
         // Clear visited marks, and after reset the occupancy too.
         S_SWEEP: begin
            occ_we = sweep_occ_ff;
            vis_we = 1'b1;
            if (sweep_cnt_ff == IW'(NCELLS - 1)) begin
               sweep_cnt_in = '0;
               state_in     = sweep_occ_ff ? S_IDLE : S_START;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + IW'(1);
            end
         end

         // Take a request word.
         S_IDLE: begin
            if (accept) begin
               rsp_len_in = 12'(found_len_ff);
               rsp_row_in = '0;
               rsp_col_in = '0;
               unique case (req_op)
                  gbps_pkg::OP_WRITE: begin
                     if ((DW'(req_cell_row) < DW'(MAX_ROWS)) &&
                         (DW'(req_cell_col) < DW'(MAX_COLS))) begin
                        occ_we    = 1'b1;
                        occ_waddr = cell_idx;
                        occ_wdata = req_occupied;
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = gbps_pkg::STATUS_DONE;
                  end
                  gbps_pkg::OP_SEARCH: begin
                     sweep_occ_in = 1'b0;
                     sweep_cnt_in = '0;
                     state_in     = S_SWEEP;
                  end
                  gbps_pkg::OP_READ: begin
                     if (found_ff && (PW'(req_path_index) < PW'(found_len_ff))) begin
                        path_re  = 1'b1;
                        state_in = S_RD_PATH;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = gbps_pkg::STATUS_RANGE;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = gbps_pkg::STATUS_DONE;
                  end
               endcase
            end
         end

         // Path read: node index is in hand, fetch the node.
         S_RD_PATH: begin
            node_re    = 1'b1;
            node_raddr = path_rdata;
            state_in   = S_RD_NODE;
         end

         S_RD_NODE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = gbps_pkg::STATUS_DONE;
               rsp_len_in    = 12'(found_len_ff);
               rsp_row_in    = 6'(node_rdata[NW-1 -: RW]);
               rsp_col_in    = 6'(node_rdata[IW+CW-1 -: CW]);
               state_in      = S_IDLE;
            end
         end

         // Check the endpoints and seed the queue with the start cell.
         S_START: begin
            found_in     = 1'b0;
            found_len_in = '0;
            if (!(start_ok && goal_ok)) begin
               state_in = S_FINISH;
            end else if (start_is_goal) begin
               found_in = 1'b1;
               state_in = S_FINISH;
            end else begin
               node_we    = 1'b1;
               node_waddr = '0;
               node_wdata = {RW'(start_row_ff), CW'(start_col_ff), IW'(0)};
               vis_we     = 1'b1;
               vis_waddr  = start_idx;
               vis_wdata  = 1'b1;
               count_in   = LW'(1);
               head_in    = '0;
               state_in   = S_POP;
            end
         end

         // Dequeue the next node, or stop when the queue is empty.
         S_POP: begin
            if (head_ff < count_ff) begin
               node_re  = 1'b1;
               state_in = S_NODE;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_NODE: begin
            cur_row_in = node_rdata[NW-1 -: RW];
            cur_col_in = node_rdata[IW+CW-1 -: CW];
            dir_in     = gbps_pkg::DIR_UP;
            state_in   = S_DIR;
         end

         // Classify one neighbor: stop on the goal, else fetch the cell bits of one inside the grid.
         S_DIR: begin
            if (nbr_flags.in_grid && nbr_flags.is_goal) begin
               found_in   = 1'b1;
               trace_k_in = IW'(head_ff);
               state_in   = S_TRACE;
            end else if (nbr_flags.in_grid) begin
               occ_re     = 1'b1;
               vis_re     = 1'b1;
               nbr_row_in = nbr_row;
               nbr_col_in = nbr_col;
               nbr_idx_in = nbr_idx;
               state_in   = S_CHECK;
            end else if (dir_ff == gbps_pkg::DIR_LEFT) begin
               head_in  = head_ff + LW'(1);
               state_in = S_POP;
            end else begin
               dir_in = dir_ff + 2'd1;
            end
         end

         // Enqueue a free, unvisited neighbor.
         S_CHECK: begin
            if (!occ_rdata && !vis_rdata && (count_ff < LW'(NCELLS))) begin
               vis_we    = 1'b1;
               vis_waddr = nbr_idx_ff;
               vis_wdata = 1'b1;
               node_we   = 1'b1;
               count_in  = count_ff + LW'(1);
            end
            if (dir_ff == gbps_pkg::DIR_LEFT) begin
               head_in  = head_ff + LW'(1);
               state_in = S_POP;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = S_DIR;
            end
         end

         // Walk parents back to the start and record the path.
         S_TRACE: begin
            path_we      = 1'b1;
            found_len_in = found_len_ff + LW'(1);
            if ((trace_k_ff == '0) || (found_len_in == LW'(NCELLS))) begin
               state_in = S_FINISH;
            end else begin
               node_re    = 1'b1;
               node_raddr = trace_k_ff;
               state_in   = S_TRACE_RD;
            end
         end

         S_TRACE_RD: begin
            trace_k_in = node_rdata[IW-1:0];
            state_in   = S_TRACE;
         end

         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? gbps_pkg::STATUS_FOUND : gbps_pkg::STATUS_NOPATH;
               rsp_len_in    = 12'(found_len_ff);
               rsp_row_in    = '0;
               rsp_col_in    = '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, registers and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_cnt_ff <= '0;
         sweep_occ_ff <= 1'b1;
         found_len_ff <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grid_rows_ff <= gbps_pkg::GRID_ROWS_RST;
         grid_cols_ff <= gbps_pkg::GRID_COLS_RST;
         start_row_ff <= gbps_pkg::START_ROW_RST;
         start_col_ff <= gbps_pkg::START_COL_RST;
         goal_row_ff  <= gbps_pkg::GOAL_ROW_RST;
         goal_col_ff  <= gbps_pkg::GOAL_COL_RST;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         sweep_occ_ff <= sweep_occ_in;
         found_len_ff <= found_len_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               gbps_pkg::REG_GRID_ROWS: grid_rows_ff <= csr_wdata;
               gbps_pkg::REG_GRID_COLS: grid_cols_ff <= csr_wdata;
               gbps_pkg::REG_START_ROW: start_row_ff <= csr_wdata[5:0];
               gbps_pkg::REG_START_COL: start_col_ff <= csr_wdata[5:0];
               gbps_pkg::REG_GOAL_ROW:  goal_row_ff  <= csr_wdata[5:0];
               gbps_pkg::REG_GOAL_COL:  goal_col_ff  <= csr_wdata[5:0];
               default: begin
               end
            endcase
         end
      end
      head_ff       <= head_in;
      count_ff      <= count_in;
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      dir_ff        <= dir_in;
      nbr_row_ff    <= nbr_row_in;
      nbr_col_ff    <= nbr_col_in;
      nbr_idx_ff    <= nbr_idx_in;
      trace_k_ff    <= trace_k_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_path_row    = rsp_row_ff;
   assign rsp_path_col    = rsp_col_ff;

endmodule

[hdl/gbps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid BFS path search checker
// Port-level assertions on the grid path search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_bfs_path_search_defines.svh"

module gbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_op,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [11:0] rsp_path_length,
   input logic [5:0]  rsp_path_row,
   input logic [5:0]  rsp_path_col
);

   // A stalled response word holds.
   `GBPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_path_length) && $stable(rsp_path_row) && $stable(rsp_path_col), "stalled response word changed")

   // An out-of-range read returns no cell.
   `GBPS_ASSERT_NOW(a_range_zero, rsp_valid && rsp_status == gbps_pkg::STATUS_RANGE, rsp_path_row == 6'd0 && rsp_path_col == 6'd0, "out-of-range read returned a cell")

   // A failed search reports an empty path.
   `GBPS_ASSERT_NOW(a_nopath_len, rsp_valid && rsp_status == gbps_pkg::STATUS_NOPATH, rsp_path_length == 12'd0, "failed search reported a path length")

   // A search keeps the request channel busy in the following cycle.
   `GBPS_ASSERT_NEXT(a_search_busy, req_valid && !req_stall && req_op == gbps_pkg::OP_SEARCH, req_stall, "request taken during a search")

endmodule

bind grid_bfs_path_search gbps_checker u_gbps_checker (.*);

[tb/sv/tb_grid_bfs_path_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid BFS path search testbench
// Loads occupancy grids, runs searches and reads back path cells under random
// gaps and stalls on both channels. Each response word is compared with a
// set word or a local BFS predictor that keeps its own grid and registers.
// ----------------------------------------------------------------------------
module tb_grid_bfs_path_search;

   localparam int NCELL      = gbps_pkg::MAX_ROWS_DEF * gbps_pkg::MAX_COLS_DEF;
   localparam int IDLE_LIMIT = 400000;
   localparam int NUM_PHASES = 12;
   localparam int PHASE_LEN  = 50;

   typedef struct {
      logic [1:0]  st;
      logic [11:0] len;
      logic [5:0]  prow;
      logic [5:0]  pcol;
   } rsp_word_type;

   typedef struct {
      logic [1:0]   op;
      logic [5:0]   row;
      logic [5:0]   col;
      logic         occ;
      logic [11:0]  idx;
      bit           typed;
      rsp_word_type want;
   } req_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = gbps_pkg::OP_NONE;
   logic [5:0]  req_cell_row = '0;
   logic [5:0]  req_cell_col = '0;
   logic        req_occupied = 1'b0;
   logic [11:0] req_path_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_path_length;
   logic [5:0]  rsp_path_row;
   logic [5:0]  rsp_path_col;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   // Grid model and the registers as the block sees them.
   bit          occ_map [NCELL];
   bit          seen_map [NCELL];
   logic [5:0]  node_row [NCELL];
   logic [5:0]  node_col [NCELL];
   int          node_parent [NCELL];
   int          trace_node [NCELL];
   int          found_len;
   bit          found;
   logic [6:0]  rows_reg, cols_reg;
   logic [5:0]  srow_reg, scol_reg, grow_reg, gcol_reg;

   rsp_word_type pending_rsp [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   bit          hold_pending = 1'b0;

   grid_bfs_path_search i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_cell_row    (req_cell_row),
      .req_cell_col    (req_cell_col),
      .req_occupied    (req_occupied),
      .req_path_index  (req_path_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_path_length (rsp_path_length),
      .rsp_path_row    (rsp_path_row),
      .rsp_path_col    (rsp_path_col),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A zero size counts as one, and a size beyond the store is clipped.
   function automatic int eff_dim(input logic [6:0] v, input int maxv);
      if (v == 0) return 1;
      return (int'(v) > maxv) ? maxv : int'(v);
   endfunction

   // Breadth-first search from start to goal, neighbors up, down, right, left.
   function automatic void run_bfs();
      int rows, cols, head, count, hit, r, c, nr, nc, id, k;
      rows = eff_dim(rows_reg, gbps_pkg::MAX_ROWS_DEF);
      cols = eff_dim(cols_reg, gbps_pkg::MAX_COLS_DEF);
      hit = -1;
      for (int i = 0; i < NCELL; i++) seen_map[i] = 1'b0;
      found = 1'b0;
      found_len = 0;
      if (srow_reg >= rows || scol_reg >= cols) return;
      if (grow_reg >= rows || gcol_reg >= cols) return;
      if (srow_reg == grow_reg && scol_reg == gcol_reg) begin
         found = 1'b1;
         return;
      end
      node_row[0] = srow_reg;
      node_col[0] = scol_reg;
      node_parent[0] = 0;
      seen_map[int'(srow_reg) * gbps_pkg::MAX_COLS_DEF + int'(scol_reg)] = 1'b1;
      count = 1;
      head = 0;
      while (head < count && hit < 0) begin
         r = node_row[head];
         c = node_col[head];
         for (int d = 0; d < 4; d++) begin
            nr = r;
            nc = c;
            case (d[1:0])
               gbps_pkg::DIR_UP:    nr = r - 1;
               gbps_pkg::DIR_DOWN:  nr = r + 1;
               gbps_pkg::DIR_RIGHT: nc = c + 1;
               default:             nc = c - 1;
            endcase
            if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
            // The goal is seen before its occupancy is looked at.
            if (nr == grow_reg && nc == gcol_reg) begin
               hit = head;
               break;
            end
            id = nr * gbps_pkg::MAX_COLS_DEF + nc;
            if (!occ_map[id] && !seen_map[id] && count < NCELL) begin
               seen_map[id] = 1'b1;
               node_row[count] = nr[5:0];
               node_col[count] = nc[5:0];
               node_parent[count] = head;
               count++;
            end
         end
         head++;
      end
      // Walk the parents back from the goal's neighbor to the start.
      if (hit >= 0) begin
         found = 1'b1;
         k = hit;
         while (found_len < NCELL) begin
            trace_node[found_len] = k;
            found_len++;
            if (k == 0) break;
            k = node_parent[k];
         end
      end
   endfunction

   // Expected response word of one request, updating the grid model.
   function automatic rsp_word_type predict_rsp(input req_word_type w);
      rsp_word_type p;
      p = '{gbps_pkg::STATUS_DONE, 12'd0, 6'd0, 6'd0};
      case (w.op)
         gbps_pkg::OP_WRITE:
            occ_map[int'(w.row) * gbps_pkg::MAX_COLS_DEF + int'(w.col)] = w.occ;
         gbps_pkg::OP_SEARCH: begin
            run_bfs();
            p.st = found ? gbps_pkg::STATUS_FOUND : gbps_pkg::STATUS_NOPATH;
         end
         gbps_pkg::OP_READ: begin
            if (found && int'(w.idx) < found_len) begin
               p.prow = node_row[trace_node[w.idx]];
               p.pcol = node_col[trace_node[w.idx]];
            end else begin
               p.st = gbps_pkg::STATUS_RANGE;
            end
         end
         default: ;
      endcase
      p.len = found_len[11:0];
      return p;
   endfunction

   // Idle length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one request word and predict its response once it is taken.
   task automatic send_word(input req_word_type w);
      int gap;
      rsp_word_type p;
      rsp_word_type q_word;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= w.op;
      req_cell_row   <= w.row;
      req_cell_col   <= w.col;
      req_occupied   <= w.occ;
      req_path_index <= w.idx;
      do @(posedge clock); while (req_stall);
      p = predict_rsp(w);
      q_word = w.typed ? w.want : p;
      pending_rsp.insert(pending_rsp.size(), q_word);
   endtask

   // Registers are written only once every response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gbps_pkg::REG_GRID_ROWS: rows_reg = data;
         gbps_pkg::REG_GRID_COLS: cols_reg = data;
         gbps_pkg::REG_START_ROW: srow_reg = data[5:0];
         gbps_pkg::REG_START_COL: scol_reg = data[5:0];
         gbps_pkg::REG_GOAL_ROW:  grow_reg = data[5:0];
         default:                 gcol_reg = data[5:0];
      endcase
   endtask

   // Pick a grid setup; the first phases walk through the special setups.
   task automatic set_phase_regs(input int kind);
      logic [6:0] nrows, ncols;
      logic [5:0] sr, sc, gr, gc;
      int er, ec;
      nrows = 7'($urandom_range(2, 12));
      ncols = 7'($urandom_range(2, 12));
      case (kind)
         0: begin
            nrows = 7'd0;
            ncols = 7'd127;
         end
         1: begin
            nrows = 7'd127;
            ncols = 7'd64;
         end
         default: ;
      endcase
      er = eff_dim(nrows, gbps_pkg::MAX_ROWS_DEF);
      ec = eff_dim(ncols, gbps_pkg::MAX_COLS_DEF);
      sr = 6'($urandom_range(0, er - 1));
      sc = 6'($urandom_range(0, ec - 1));
      gr = 6'($urandom_range(0, er - 1));
      gc = 6'($urandom_range(0, ec - 1));
      case (kind)
         2: sr = 6'($urandom_range(er, 63));
         3: begin
            gr = sr;
            gc = sc;
         end
         4: begin
            gr = sr;
            gc = (int'(sc) + 1 < ec) ? (sc + 6'd1) : (sc - 6'd1);
         end
         5: gc = 6'($urandom_range(ec, 63));
         default: ;
      endcase
      write_reg(gbps_pkg::REG_GRID_ROWS, nrows);
      write_reg(gbps_pkg::REG_GRID_COLS, ncols);
      write_reg(gbps_pkg::REG_START_ROW, {1'b0, sr});
      write_reg(gbps_pkg::REG_START_COL, {1'b0, sc});
      write_reg(gbps_pkg::REG_GOAL_ROW, {1'b0, gr});
      write_reg(gbps_pkg::REG_GOAL_COL, {1'b0, gc});
      csr_valid <= 1'b0;
   endtask

   // Receiver stalls, with one long hold-off that backs up the block.
   initial begin
      int n;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 7)) @(posedge clock);
         end
      end
   end

   // Compare each response word with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with no request outstanding");
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.st) begin
               $error("status: expected %0d, got %0d", e.st, rsp_status);
               errors++;
            end
            if (rsp_path_length !== e.len) begin
               $error("path_length: expected %0d, got %0d", e.len, rsp_path_length);
               errors++;
            end
            if (rsp_path_row !== e.prow) begin
               $error("path_row: expected %0d, got %0d", e.prow, rsp_path_row);
               errors++;
            end
            if (rsp_path_col !== e.pcol) begin
               $error("path_col: expected %0d, got %0d", e.pcol, rsp_path_col);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles in which no channel moves a word.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Directed words on the reset grid: start (2,2), goal (7,2), 64 x 64.
   req_word_type directed [] = '{
      '{gbps_pkg::OP_NONE,   6'd0,  6'd0,  1'b0, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_READ,   6'd0,  6'd0,  1'b0, 12'hFFF, 1'b1,
        '{gbps_pkg::STATUS_RANGE,  12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_WRITE,  6'd63, 6'd63, 1'b1, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_WRITE,  6'd0,  6'd0,  1'b1, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_WRITE,  6'd0,  6'd0,  1'b0, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_SEARCH, 6'd0,  6'd0,  1'b0, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_FOUND,  12'd5, 6'd0, 6'd0}},
      '{gbps_pkg::OP_READ,   6'd0,  6'd0,  1'b0, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd5, 6'd6, 6'd2}},
      '{gbps_pkg::OP_READ,   6'd0,  6'd0,  1'b0, 12'd4,   1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd5, 6'd2, 6'd2}},
      '{gbps_pkg::OP_READ,   6'd0,  6'd0,  1'b0, 12'd5,   1'b1,
        '{gbps_pkg::STATUS_RANGE,  12'd5, 6'd0, 6'd0}},
      // Blocked start and goal, then a wall that forces a detour.
      '{gbps_pkg::OP_WRITE,  6'd7,  6'd2,  1'b1, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd5, 6'd0, 6'd0}},
      '{gbps_pkg::OP_WRITE,  6'd2,  6'd2,  1'b1, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd5, 6'd0, 6'd0}},
      '{gbps_pkg::OP_WRITE,  6'd5,  6'd2,  1'b1, 12'd0,   1'b0,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_SEARCH, 6'd0,  6'd0,  1'b0, 12'd0,   1'b0,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_READ,   6'd0,  6'd0,  1'b0, 12'd0,   1'b0,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_READ,   6'd0,  6'd0,  1'b0, 12'd3,   1'b0,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      // Wall in the goal on all four sides: the queue runs dry.
      '{gbps_pkg::OP_WRITE,  6'd6,  6'd2,  1'b1, 12'd0,   1'b0,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_WRITE,  6'd8,  6'd2,  1'b1, 12'd0,   1'b0,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_WRITE,  6'd7,  6'd1,  1'b1, 12'd0,   1'b0,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_WRITE,  6'd7,  6'd3,  1'b1, 12'd0,   1'b0,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_SEARCH, 6'd0,  6'd0,  1'b0, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_NOPATH, 12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_READ,   6'd0,  6'd0,  1'b0, 12'd0,   1'b1,
        '{gbps_pkg::STATUS_RANGE,  12'd0, 6'd0, 6'd0}},
      '{gbps_pkg::OP_NONE,   6'd63, 6'd63, 1'b1, 12'hFFF, 1'b1,
        '{gbps_pkg::STATUS_DONE,   12'd0, 6'd0, 6'd0}}
   };

   // Main stimulus: reset, directed words, then random grid phases.
   initial begin
      req_word_type w;
      int r, dens, er, ec;
      for (int i = 0; i < NCELL; i++) occ_map[i] = 1'b0;
      found = 1'b0;
      found_len = 0;
      rows_reg = gbps_pkg::GRID_ROWS_RST;
      cols_reg = gbps_pkg::GRID_COLS_RST;
      srow_reg = gbps_pkg::START_ROW_RST;
      scol_reg = gbps_pkg::START_COL_RST;
      grow_reg = gbps_pkg::GOAL_ROW_RST;
      gcol_reg = gbps_pkg::GOAL_COL_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_word(directed[i]);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         set_phase_regs((ph < 7) ? ph : int'($urandom_range(2, 9)));
         calm = ($urandom_range(0, 3) == 0);
         if (ph == 2) hold_pending = 1'b1;
         dens = $urandom_range(5, 45);
         er = eff_dim(rows_reg, gbps_pkg::MAX_ROWS_DEF);
         ec = eff_dim(cols_reg, gbps_pkg::MAX_COLS_DEF);
         for (int n = 0; n < PHASE_LEN; n++) begin
            w = '{gbps_pkg::OP_WRITE, 6'($urandom_range(0, 63)),
                  6'($urandom_range(0, 63)), ($urandom_range(0, 99) < dens),
                  12'($urandom_range(0, 4095)), 1'b0,
                  '{gbps_pkg::STATUS_DONE, 12'd0, 6'd0, 6'd0}};
            r = $urandom_range(0, 99);
            if (r < 55) begin
               if ($urandom_range(0, 99) < 85) begin
                  w.row = 6'($urandom_range(0, er - 1));
                  w.col = 6'($urandom_range(0, ec - 1));
               end
            end else if (r < 63) begin
               w.op = gbps_pkg::OP_SEARCH;
            end else if (r < 95) begin
               w.op = gbps_pkg::OP_READ;
               if (found_len > 0 && $urandom_range(0, 99) < 80)
                  w.idx = 12'($urandom_range(0, found_len));
            end else begin
               w.op = gbps_pkg::OP_NONE;
            end
            send_word(w);
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
